// ===== design/ctre_pkg.sv =====
`timescale 1ns / 1ps

package ctre_pkg;

  localparam int MAX_COLUMNS = 512;
  localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
  localparam int CLR_CNT_W   = $clog2(MAX_COLUMNS + 1);

  localparam int COLUMN_W  = 9;
  localparam int ROW_W     = 10;
  localparam int ALPHA_W   = 8;
  localparam int HEIGHT_W  = 11;
  localparam int CBASE_W   = 10;
  localparam int SCOL_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [HEIGHT_W-1:0] VIEW_HEIGHT_RST = 11'd200;
  localparam logic [HEIGHT_W-1:0] FOG_HORIZON_RST = 11'd200;
  localparam logic [CBASE_W-1:0]  COLUMN_BASE_RST = 10'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_HEIGHT = 2'd0,
    CFG_FOG_HORIZON = 2'd1,
    CFG_COLUMN_BASE = 2'd2
  } cfg_idx_t;

  localparam logic KIND_SKY = 1'b0;
  localparam logic KIND_FOG = 1'b1;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [ALPHA_W-1:0]  alpha;
  } in_beat_t;

  typedef struct packed {
    logic [SCOL_W-1:0]   screen_column;
    logic [ROW_W-1:0]    run_start;
    logic [HEIGHT_W-1:0] run_end;
    logic                run_kind;
    logic                last_of_item;
  } out_beat_t;

  // per-column entry: open flag and start row
  typedef struct packed {
    logic             open;
    logic [ROW_W-1:0] start;
  } col_entry_t;

endpackage

// ===== design/ctre_in_if.sv =====
`timescale 1ns / 1ps

interface ctre_in_if;
  import ctre_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ctre_out_if.sv =====
`timescale 1ns / 1ps

interface ctre_out_if;
  import ctre_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/column_transparent_run_extractor.sv =====
`timescale 1ns / 1ps
// channel   dir  beat fields
// in_ch     in   column, row, alpha
// out_ch    out  screen_column, run_start, run_end, run_kind, last_of_item
// cfg_*     in   write enable, register index, write data
//
// one pixel per cycle while the output queue has room and no clear runs; a pixel is read from
// the column memory at acceptance and written back when it leaves its stage, with the last write forwarded
// a pixel that splits into sky and fog parts gives two output beats, sky part first
// the two-entry output queue lets the next pixel enter while results wait
// after reset a pass clears all 512 entries of the column memory; no pixel is taken then
// a stalled output holds the pending pixel, and the input stalls behind it

module column_transparent_run_extractor (
  input  logic                           clk,
  input  logic                           rst_n,
  ctre_in_if.sink                        in_ch,
  ctre_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ctre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctre_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctre_pkg::*;

  col_entry_t mem [MAX_COLUMNS];

  logic [HEIGHT_W-1:0] view_height_r;
  logic [HEIGHT_W-1:0] fog_horizon_r;
  logic [CBASE_W-1:0]  column_base_r;

  logic                 clearing_r;
  logic [CLR_CNT_W-1:0] clr_cnt_r;

  logic       s1_valid_r;
  in_beat_t   s1_beat_r;
  col_entry_t rd_data_r;

  logic                 fwd_valid_r;
  logic [COL_IDX_W-1:0] fwd_idx_r;
  col_entry_t           fwd_data_r;

  out_beat_t  q_r [2];
  out_beat_t  q_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  logic                 in_fire;
  logic                 pop;
  logic                 s1_fire;
  logic [COL_IDX_W-1:0] s1_idx;
  col_entry_t           cur;
  logic                 in_view;
  logic                 last_row;
  logic                 transp;
  logic [ROW_W-1:0]     start_eff;
  logic                 emit;
  logic [HEIGHT_W-1:0]  run_s;
  logic [HEIGHT_W-1:0]  run_e;
  logic [HEIGHT_W-1:0]  hz;
  logic [HEIGHT_W-1:0]  split_lo;
  logic [HEIGHT_W-1:0]  split;
  logic                 has_sky;
  logic                 has_fog;
  logic [1:0]           n_res;
  logic [2:0]           free;
  logic                 wr_en;
  col_entry_t           wr_data;
  logic [SCOL_W-1:0]    scol;
  out_beat_t            res_first;
  out_beat_t            res_second;
  logic [1:0]           cnt_pop;

  assign pop     = (cnt_r != 2'd0) && out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign s1_idx  = s1_beat_r.column[COL_IDX_W-1:0];

  always_comb begin
    cur = rd_data_r;
    if (fwd_valid_r && (fwd_idx_r == s1_idx)) begin
      cur = fwd_data_r;
    end
    in_view   = (32'(s1_beat_r.column) < MAX_COLUMNS) &&
                ({1'b0, s1_beat_r.row} < view_height_r);
    last_row  = ({1'b0, s1_beat_r.row} + 11'd1) == view_height_r;
    transp    = s1_beat_r.alpha == '0;
    start_eff = cur.open ? cur.start : s1_beat_r.row;

    emit    = 1'b0;
    wr_en   = 1'b0;
    wr_data = cur;
    run_s   = {1'b0, start_eff};
    run_e   = {1'b0, s1_beat_r.row};
    if (in_view) begin
      if (transp) begin
        wr_en         = 1'b1;
        wr_data.open  = !last_row;
        wr_data.start = start_eff;
        if (last_row) begin
          emit  = 1'b1;
          run_e = view_height_r;
        end
      end else if (cur.open) begin
        wr_en        = 1'b1;
        wr_data.open = 1'b0;
        emit         = 1'b1;
      end
    end

    hz       = (fog_horizon_r > view_height_r) ? view_height_r : fog_horizon_r;
    split_lo = (run_s > hz) ? run_s : hz;
    split    = (split_lo > run_e) ? run_e : split_lo;
    has_sky  = emit && (run_s < split);
    has_fog  = emit && (split < run_e);
    n_res    = {1'b0, has_sky} + {1'b0, has_fog};

    scol = {1'b0, column_base_r} + {2'b0, s1_beat_r.column};

    res_first.screen_column = scol;
    res_first.run_start     = has_sky ? run_s[ROW_W-1:0] : split[ROW_W-1:0];
    res_first.run_end       = has_sky ? split : run_e;
    res_first.run_kind      = has_sky ? KIND_SKY : KIND_FOG;
    res_first.last_of_item  = !(has_sky && has_fog);

    res_second.screen_column = scol;
    res_second.run_start     = split[ROW_W-1:0];
    res_second.run_end       = run_e;
    res_second.run_kind      = KIND_FOG;
    res_second.last_of_item  = 1'b1;

    free    = 3'd2 - {1'b0, cnt_r} + {2'b0, pop};
    s1_fire = s1_valid_r && ({1'b0, n_res} <= free);
  end

  assign in_ch.ready = !clearing_r && (!s1_valid_r || s1_fire);

  always_comb begin
    q_nxt   = q_r;
    cnt_pop = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_pop  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_pop;
    if (s1_fire && (n_res != 2'd0)) begin
      q_nxt[cnt_pop[0]] = res_first;
      if (n_res == 2'd2) begin
        q_nxt[1] = res_second;
      end
      cnt_nxt = cnt_pop + n_res;
    end
  end

  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.data  = q_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_height_r <= VIEW_HEIGHT_RST;
      fog_horizon_r <= FOG_HORIZON_RST;
      column_base_r <= COLUMN_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VIEW_HEIGHT: view_height_r <= cfg_data;
        CFG_FOG_HORIZON: fog_horizon_r <= cfg_data;
        CFG_COLUMN_BASE: column_base_r <= cfg_data[CBASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == MAX_COLUMNS - 1) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en && s1_fire) begin
        fwd_valid_r <= 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat_r <= in_ch.data;
      rd_data_r <= mem[in_ch.data.column[COL_IDX_W-1:0]];
    end
    if (clearing_r) begin
      mem[clr_cnt_r[COL_IDX_W-1:0]] <= '0;
    end else if (wr_en && s1_fire) begin
      mem[s1_idx] <= wr_data;
    end
    if (wr_en && s1_fire) begin
      fwd_idx_r  <= s1_idx;
      fwd_data_r <= wr_data;
    end
    q_r <= q_nxt;
  end

`ifndef SYNTH
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ch.ready)
    else $error("input taken during memory clear");

  a_no_item_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r)
    else $error("pixel pending during memory clear");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue overflow");

  a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.data.last_of_item) |=>
      (out_ch.valid && out_ch.data.run_kind == KIND_FOG))
    else $error("sky part not followed by its fog part");
`endif

endmodule

// ===== sim/tb_column_transparent_run_extractor.sv =====
`timescale 1ns / 1ps

module tb_column_transparent_run_extractor;
  import ctre_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ctre_in_if in_ch();
  ctre_out_if out_ch();

  column_transparent_run_extractor DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block: register values and per-column open runs
  int unsigned view_h = VIEW_HEIGHT_RST;
  int unsigned fog_h = FOG_HORIZON_RST;
  int unsigned col_base = COLUMN_BASE_RST;
  bit col_open [MAX_COLUMNS];
  logic [ROW_W-1:0] col_start [MAX_COLUMNS];
  out_beat_t pending_runs [$];

  int n_errors = 0;
  int n_pixels = 0;
  int n_runs_checked = 0;
  int n_writes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void push_run_parts(input logic [SCOL_W-1:0] scol,
                                         input int unsigned s, input int unsigned e);
    int unsigned hz;
    int unsigned split;
    out_beat_t part;
    hz = (fog_h > view_h) ? view_h : fog_h;
    split = (s > hz) ? s : hz;
    if (split > e) split = e;
    part.screen_column = scol;
    if (s < split) begin
      part.run_start = ROW_W'(s);
      part.run_end = HEIGHT_W'(split);
      part.run_kind = KIND_SKY;
      part.last_of_item = (split >= e);
      pending_runs.push_back(part);
    end
    if (split < e) begin
      part.run_start = ROW_W'(split);
      part.run_end = HEIGHT_W'(e);
      part.run_kind = KIND_FOG;
      part.last_of_item = 1'b1;
      pending_runs.push_back(part);
    end
  endfunction

  function automatic void predict_pixel(input in_beat_t px);
    int unsigned c;
    int unsigned r;
    logic [SCOL_W-1:0] scol;
    c = px.column;
    r = px.row;
    if (r >= view_h) return;
    scol = SCOL_W'(col_base + c);
    if (px.alpha == '0) begin
      if (!col_open[c]) begin
        col_open[c] = 1'b1;
        col_start[c] = px.row;
      end
      if (r + 1 == view_h) begin
        push_run_parts(scol, col_start[c], view_h);
        col_open[c] = 1'b0;
      end
    end else if (col_open[c]) begin
      push_run_parts(scol, col_start[c], r);
      col_open[c] = 1'b0;
    end
  endfunction

  function automatic in_beat_t make_pixel(input int unsigned c, input int unsigned r,
                                          input int unsigned a);
    in_beat_t px;
    px.column = COLUMN_W'(c);
    px.row = ROW_W'(r);
    px.alpha = ALPHA_W'(a);
    return px;
  endfunction

  function automatic int unsigned rand_alpha(input int unsigned clear_pct);
    return ($urandom_range(99) < clear_pct) ? 0 : $urandom_range(1, 255);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(input in_beat_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= px;
    do @(posedge clk); while (!in_ch.ready);
    predict_pixel(px);
    n_pixels++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_VIEW_HEIGHT: view_h = value & 'h7FF;
      CFG_FOG_HORIZON: fog_h = value & 'h7FF;
      CFG_COLUMN_BASE: col_base = value & 'h3FF;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // pixels that give no run may still be in flight when the queue empties
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_defaults();
    send_pixel(make_pixel(0, 10, 0));
    send_pixel(make_pixel(0, 50, 255));
    send_pixel(make_pixel(511, 0, 0));
    send_pixel(make_pixel(511, 199, 0));
    send_pixel(make_pixel(7, 300, 0));
    send_pixel(make_pixel(7, 1023, 0));
    send_pixel(make_pixel(7, 20, 1));
  endtask

  task automatic test_fog_split();
    wait_idle();
    write_reg(CFG_VIEW_HEIGHT, 16);
    write_reg(CFG_FOG_HORIZON, 8);
    write_reg(CFG_COLUMN_BASE, 1023);
    send_pixel(make_pixel(511, 2, 0));
    send_pixel(make_pixel(511, 12, 128));
    send_pixel(make_pixel(3, 9, 0));
    send_pixel(make_pixel(3, 11, 255));
    send_pixel(make_pixel(4, 15, 0));
    // close on the opening row
    send_pixel(make_pixel(5, 5, 0));
    send_pixel(make_pixel(5, 5, 1));
    // close above the opening row
    send_pixel(make_pixel(6, 10, 0));
    send_pixel(make_pixel(6, 4, 1));
  endtask

  task automatic test_view_extremes();
    wait_idle();
    write_reg(CFG_VIEW_HEIGHT, 1);
    write_reg(CFG_FOG_HORIZON, 2047);
    write_reg(CFG_COLUMN_BASE, 0);
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(1, 0, 255));
    wait_idle();
    write_reg(CFG_VIEW_HEIGHT, 1024);
    write_reg(CFG_FOG_HORIZON, 0);
    send_pixel(make_pixel(9, 0, 0));
    send_pixel(make_pixel(9, 1023, 0));
    send_pixel(make_pixel(2, 1023, 0));
    // taller than any row: only opaque pixels end runs
    wait_idle();
    write_reg(CFG_VIEW_HEIGHT, 1100);
    write_reg(CFG_FOG_HORIZON, 512);
    send_pixel(make_pixel(10, 100, 0));
    send_pixel(make_pixel(10, 1023, 0));
    send_pixel(make_pixel(10, 1023, 1));
    wait_idle();
    write_reg(CFG_VIEW_HEIGHT, 0);
    send_pixel(make_pixel(11, 0, 0));
    send_pixel(make_pixel(11, 0, 255));
  endtask

  task automatic random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned vh;
    int unsigned fh;
    int unsigned ncols;
    int unsigned c0;
    int unsigned step;
    int unsigned r;
    int unsigned k;
    bit frame_done;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      if ($urandom_range(9) == 0) vh = $urandom_range(1000, 1100);
      else vh = $urandom_range(2, 24);
      case ($urandom_range(5))
        0: fh = 2047;
        1: fh = vh + $urandom_range(1, 8);
        default: fh = $urandom_range(0, vh);
      endcase
      write_reg(CFG_VIEW_HEIGHT, vh);
      write_reg(CFG_FOG_HORIZON, fh);
      write_reg(CFG_COLUMN_BASE, ($urandom_range(3) == 0) ? 1023 : $urandom_range(0, 1023));
      ncols = $urandom_range(1, 5);
      c0 = $urandom_range(0, MAX_COLUMNS - ncols);
      step = (vh > 64) ? vh / 6 : 1;
      r = 0;
      frame_done = 1'b0;
      while (!frame_done) begin
        for (k = 0; k < ncols; k++) begin
          if ($urandom_range(9) == 0) begin
            send_pixel(make_pixel($urandom_range(0, MAX_COLUMNS - 1), $urandom_range(0, 1023),
                                  rand_alpha(50)));
          end
          send_pixel(make_pixel(c0 + k, r, rand_alpha(60)));
          sent++;
        end
        if (r >= vh - 1 || r >= 1023) begin
          frame_done = 1'b1;
        end else begin
          r = r + step;
          if (r > vh - 1) r = vh - 1;
          if (r > 1023) r = 1023;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    int unsigned k;
    wait_idle();
    write_reg(CFG_VIEW_HEIGHT, 64);
    write_reg(CFG_FOG_HORIZON, 32);
    write_reg(CFG_COLUMN_BASE, 100);
    hold_req = 1'b1;
    for (k = 0; k < 16; k++) send_pixel(make_pixel(k, 10, 0));
    for (k = 0; k < 16; k++) send_pixel(make_pixel(k, 40, 1 + k * 16));
  endtask

  // long output hold-off
  initial begin
    forever begin
      wait (hold_req);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
      hold_req = 1'b0;
    end
  end

  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (hold_active) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_runs
    out_beat_t want;
    out_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run beat col %0d [%0d,%0d) kind %0d",
                                  got.screen_column, got.run_start, got.run_end, got.run_kind));
      end else begin
        want = pending_runs.pop_front();
        n_runs_checked++;
        if (got.screen_column !== want.screen_column)
          report_mismatch($sformatf("screen_column got %0d want %0d",
                                    got.screen_column, want.screen_column));
        if (got.run_start !== want.run_start)
          report_mismatch($sformatf("run_start got %0d want %0d", got.run_start, want.run_start));
        if (got.run_end !== want.run_end)
          report_mismatch($sformatf("run_end got %0d want %0d", got.run_end, want.run_end));
        if (got.run_kind !== want.run_kind)
          report_mismatch($sformatf("run_kind got %0d want %0d", got.run_kind, want.run_kind));
        if (got.last_of_item !== want.last_of_item)
          report_mismatch($sformatf("last_of_item got %0d want %0d",
                                    got.last_of_item, want.last_of_item));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d runs outstanding", pending_runs.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run_tests
    int settle;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    set_idling(36, 88);
    test_defaults();
    test_fog_split();
    test_view_extremes();
    random_frames(100);
    set_idling(88, 36);
    random_frames(100);
    set_idling(0, 0);
    random_frames(100);
    test_output_backpressure();

    in_ch.valid <= 1'b0;
    settle = 0;
    while (pending_runs.size() != 0 && settle < 50000) begin
      @(negedge clk);
      settle++;
    end
    repeat (16) @(negedge clk);
    if (pending_runs.size() != 0)
      report_mismatch($sformatf("%0d expected runs never arrived", pending_runs.size()));

    $display("run covered %0d pixels, %0d run beats compared, %0d register writes",
             n_pixels, n_runs_checked, n_writes);
    $display("stalls on either side, none, and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
